// ----- sv/clnb_pkg.sv -----
// Shared constants, codes and control types of the cell-list neighbour binning block.
package clnb_pkg;

	localparam int GRID_MAX     = 32;
	localparam int GRID_W       = $clog2(GRID_MAX);
	localparam int GSIZE_W      = 6;
	localparam int CELL_W       = 2 * GRID_W;
	localparam int BOX_CAP      = 7;
	localparam int SLOT_W       = 3;
	localparam int PARTICLE_MAX = 1024;
	localparam int IDX_W        = 10;
	localparam int MEM_AW       = CELL_W + SLOT_W;
	localparam int HALF_W       = 31;
	localparam int INV_W        = 25;
	localparam int POS_W        = 32;
	localparam int SUM_W        = POS_W + 1;
	localparam int PART_W       = 16;
	localparam int MUL_W        = PART_W + INV_W;
	localparam int ACC_W        = POS_W + INV_W;
	localparam int CFG_W        = 31;
	localparam int CFG_IDX_W    = 2;
	localparam int REM_W        = 6;
	localparam int WALK_N       = 9;
	localparam int WALK_W       = 4;

	localparam logic [1:0] OP_LOCATE = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_MOVE   = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_BOX   = 2'd2;

	// Fill store read address select.
	localparam logic [1:0] FR_LOC  = 2'd0;
	localparam logic [1:0] FR_OLD  = 2'd1;
	localparam logic [1:0] FR_NEW  = 2'd2;
	localparam logic [1:0] FR_WALK = 2'd3;

	// Fill store write select.
	localparam logic [1:0] FW_CLR = 2'd0;
	localparam logic [1:0] FW_LOC = 2'd1;
	localparam logic [1:0] FW_OLD = 2'd2;
	localparam logic [1:0] FW_NEW = 2'd3;

	typedef struct packed {
		logic       capture;
		logic       clr_step;
		logic       mul;
		logic       mul_hi;
		logic       axis_y;
		logic       acc_lo;
		logic       acc_hi;
		logic       save;
		logic       frd;
		logic [1:0] frd_sel;
		logic       fwr;
		logic [1:0] fwr_sel;
		logic       n_load;
		logic       slot_clr;
		logic       scan_rd;
		logic       cmp_rd;
		logic       fnew_load;
		logic       mwr_ins;
		logic       mwr_new;
		logic       walk_init;
		logic       walk_next;
		logic       rem_clr;
		logic       rem_dec;
		logic       q_load;
		logic       qrd;
		logic       emit;
		logic [1:0] e_status;
		logic       e_cell;
		logic       e_found;
		logic       e_last;
	} clnb_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       clr_last;
		logic       loc_ok;
		logic       idx_bad;
		logic       fill_full;
		logic       same_cell;
		logic       mv_oob;
		logic       q_oob;
		logic       slot_end;
		logic       slot_zero;
		logic       present;
		logic       walk_last;
		logic       rem_zero;
		logic       rem_one;
		logic       cell_empty;
		logic       out_free;
	} clnb_stat_t;

endpackage

// ----- sv/clnb_dp.sv -----
// Datapath: configuration, locate arithmetic, cell stores, walk counters and result register.
module clnb_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  clnb_pkg::clnb_cmd_t                 cmd,
	output clnb_pkg::clnb_stat_t                st,
	input  logic                                cfg_we,
	input  logic [clnb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [clnb_pkg::CFG_W-1:0]          cfg_data,
	input  logic [1:0]                          operation,
	input  logic [clnb_pkg::IDX_W-1:0]          particle_index,
	input  logic signed [clnb_pkg::POS_W-1:0]   pos_x,
	input  logic signed [clnb_pkg::POS_W-1:0]   pos_y,
	input  logic [clnb_pkg::GRID_W-1:0]         cell_x,
	input  logic [clnb_pkg::GRID_W-1:0]         cell_y,
	input  logic [clnb_pkg::GRID_W-1:0]         new_cell_x,
	input  logic [clnb_pkg::GRID_W-1:0]         new_cell_y,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [clnb_pkg::IDX_W-1:0]          member_index,
	output logic                                found,
	output logic [clnb_pkg::GRID_W-1:0]         out_cell_x,
	output logic [clnb_pkg::GRID_W-1:0]         out_cell_y,
	output logic [1:0]                          status,
	output logic                                last
);

	logic [clnb_pkg::GSIZE_W-1:0] grid_q;
	logic [clnb_pkg::HALF_W-1:0]  half_q;
	logic [clnb_pkg::INV_W-1:0]   inv_q;
	logic [clnb_pkg::GSIZE_W-1:0] g;

	logic [1:0]                   op_q;
	logic [clnb_pkg::IDX_W-1:0]   idx_q;
	logic [clnb_pkg::GRID_W-1:0]  cx_q, cy_q, nx_q, ny_q;
	logic [clnb_pkg::SUM_W-1:0]   sumx_q, sumy_q;

	logic [clnb_pkg::PART_W-1:0]  mul_a;
	logic [clnb_pkg::SUM_W-1:0]   sum_sel;
	logic [clnb_pkg::MUL_W-1:0]   mul_q;
	logic [clnb_pkg::ACC_W-1:0]   acc_q;
	logic                         axis_ok;
	logic [clnb_pkg::GRID_W-1:0]  locx_q, locy_q;
	logic                         okx_q, oky_q;

	logic [clnb_pkg::GRID_W-1:0]  clr_q;
	logic [clnb_pkg::SLOT_W-1:0]  fill_mem [2**clnb_pkg::CELL_W];
	logic [clnb_pkg::SLOT_W-1:0]  fill_rd_q;
	logic [clnb_pkg::CELL_W-1:0]  frd_addr, fwr_addr;
	logic [clnb_pkg::SLOT_W-1:0]  fwr_data;
	logic [clnb_pkg::CELL_W-1:0]  clr_cnt_q;

	logic [clnb_pkg::IDX_W-1:0]   mem [2**clnb_pkg::MEM_AW];
	logic [clnb_pkg::IDX_W-1:0]   mrd_q;
	logic [clnb_pkg::MEM_AW-1:0]  mrd_addr, mwr_addr;
	logic [clnb_pkg::IDX_W-1:0]   mwr_data;
	logic                         mre, mwe, match;

	logic [clnb_pkg::SLOT_W-1:0]  n_q, slot_q, keep_q, fnew_q;
	logic                         scan_chk_q, cmp_chk_q, present_q;

	logic [clnb_pkg::GRID_W-1:0]  wx_q, wy_q, x0, x1, y0, y1;
	logic [clnb_pkg::WALK_W-1:0]  k_q, kw_q;
	logic                         fcap_q;
	logic [clnb_pkg::SLOT_W-1:0]  fills_q [clnb_pkg::WALK_N];
	logic [clnb_pkg::REM_W-1:0]   rem_q;

	logic [clnb_pkg::CELL_W-1:0]  loc_cell, old_cell, new_cell, walk_cell;

	assign g = (grid_q > clnb_pkg::GSIZE_W'(clnb_pkg::GRID_MAX)) ?
		clnb_pkg::GSIZE_W'(clnb_pkg::GRID_MAX) : grid_q;

	assign loc_cell  = {locx_q, locy_q};
	assign old_cell  = {cx_q, cy_q};
	assign new_cell  = {nx_q, ny_q};
	assign walk_cell = {wx_q, wy_q};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= clnb_pkg::GSIZE_W'(32);
			half_q <= clnb_pkg::HALF_W'(1048576);
			inv_q  <= clnb_pkg::INV_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				clnb_pkg::REG_GRID_SIZE: grid_q <= cfg_data[clnb_pkg::GSIZE_W-1:0];
				clnb_pkg::REG_HALF_LEN:  half_q <= cfg_data[clnb_pkg::HALF_W-1:0];
				clnb_pkg::REG_INV_BOX:   inv_q  <= cfg_data[clnb_pkg::INV_W-1:0];
				default: ;
			endcase
		end
	end

	// Input word capture; the offset sums are formed on the way in.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			idx_q  <= particle_index;
			cx_q   <= cell_x;
			cy_q   <= cell_y;
			nx_q   <= new_cell_x;
			ny_q   <= new_cell_y;
			sumx_q <= {pos_x[clnb_pkg::POS_W-1], pos_x} + {2'b00, half_q};
			sumy_q <= {pos_y[clnb_pkg::POS_W-1], pos_y} + {2'b00, half_q};
		end
	end

	// Locate: 32 x 25 product built from two 16-bit partial products.
	assign sum_sel = cmd.axis_y ? sumy_q : sumx_q;
	assign mul_a   = cmd.mul_hi ? sum_sel[2*clnb_pkg::PART_W-1:clnb_pkg::PART_W]
	                            : sum_sel[clnb_pkg::PART_W-1:0];
	assign axis_ok = !sum_sel[clnb_pkg::SUM_W-1] &&
		(acc_q[clnb_pkg::ACC_W-1:clnb_pkg::POS_W] < clnb_pkg::INV_W'(g));

	always_ff @(posedge clk) begin
		if (cmd.mul)
			mul_q <= clnb_pkg::MUL_W'(mul_a) * clnb_pkg::MUL_W'(inv_q);
		if (cmd.acc_lo)
			acc_q <= clnb_pkg::ACC_W'(mul_q);
		else if (cmd.acc_hi)
			acc_q <= acc_q + {mul_q, {clnb_pkg::PART_W{1'b0}}};
		if (cmd.save) begin
			if (cmd.axis_y) begin
				locy_q <= acc_q[clnb_pkg::POS_W+clnb_pkg::GRID_W-1:clnb_pkg::POS_W];
				oky_q  <= axis_ok;
			end else begin
				locx_q <= acc_q[clnb_pkg::POS_W+clnb_pkg::GRID_W-1:clnb_pkg::POS_W];
				okx_q  <= axis_ok;
			end
		end
	end

	// Fill count store.
	always_comb begin
		case (cmd.frd_sel)
			clnb_pkg::FR_LOC: frd_addr = loc_cell;
			clnb_pkg::FR_OLD: frd_addr = old_cell;
			clnb_pkg::FR_NEW: frd_addr = new_cell;
			default:          frd_addr = walk_cell;
		endcase
		case (cmd.fwr_sel)
			clnb_pkg::FW_CLR: begin
				fwr_addr = clr_cnt_q;
				fwr_data = '0;
			end
			clnb_pkg::FW_LOC: begin
				fwr_addr = loc_cell;
				fwr_data = fill_rd_q + 1'b1;
			end
			clnb_pkg::FW_OLD: begin
				fwr_addr = old_cell;
				fwr_data = keep_q;
			end
			default: begin
				fwr_addr = new_cell;
				fwr_data = fnew_q + 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.fwr)
			fill_mem[fwr_addr] <= fwr_data;
		if (cmd.frd)
			fill_rd_q <= fill_mem[frd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_step)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// Member store.
	assign match = (mrd_q == idx_q);
	assign mre   = cmd.scan_rd || cmd.cmp_rd || cmd.qrd;
	assign mrd_addr = cmd.qrd ? {walk_cell, slot_q - 1'b1} : {old_cell, slot_q};

	always_comb begin
		mwe      = 1'b0;
		mwr_addr = {new_cell, fnew_q};
		mwr_data = idx_q;
		if (cmp_chk_q && !match) begin
			mwe      = 1'b1;
			mwr_addr = {old_cell, keep_q};
			mwr_data = mrd_q;
		end else if (cmd.mwr_ins) begin
			mwe      = 1'b1;
			mwr_addr = {loc_cell, fill_rd_q};
		end else if (cmd.mwr_new) begin
			mwe = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mwe)
			mem[mwr_addr] <= mwr_data;
		if (mre)
			mrd_q <= mem[mrd_addr];
	end

	// Slot counting, presence scan and compaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_chk_q <= 1'b0;
			cmp_chk_q  <= 1'b0;
			fcap_q     <= 1'b0;
		end else begin
			scan_chk_q <= cmd.scan_rd;
			cmp_chk_q  <= cmd.cmp_rd;
			fcap_q     <= cmd.frd && (cmd.frd_sel == clnb_pkg::FR_WALK);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.n_load)
			n_q <= fill_rd_q;
		if (cmd.fnew_load)
			fnew_q <= fill_rd_q;
		if (cmd.slot_clr) begin
			slot_q    <= '0;
			keep_q    <= '0;
			present_q <= 1'b0;
		end else begin
			if (cmd.scan_rd || cmd.cmp_rd)
				slot_q <= slot_q + 1'b1;
			else if (cmd.qrd)
				slot_q <= slot_q - 1'b1;
			else if (cmd.q_load)
				slot_q <= fills_q[k_q];
			if (scan_chk_q && match)
				present_q <= 1'b1;
			if (cmp_chk_q && !match)
				keep_q <= keep_q + 1'b1;
		end
	end

	// Neighbour block walk, x outer and y inner, clipped at the grid edge.
	assign x0 = (cx_q == '0) ? cx_q : cx_q - 1'b1;
	assign y0 = (cy_q == '0) ? cy_q : cy_q - 1'b1;
	assign x1 = ({1'b0, cx_q} + 1'b1 < g) ? cx_q + 1'b1 : cx_q;
	assign y1 = ({1'b0, cy_q} + 1'b1 < g) ? cy_q + 1'b1 : cy_q;

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			wx_q <= x0;
			wy_q <= y0;
			k_q  <= '0;
		end else if (cmd.walk_next) begin
			k_q <= k_q + 1'b1;
			if (wy_q == y1) begin
				wy_q <= y0;
				wx_q <= wx_q + 1'b1;
			end else begin
				wy_q <= wy_q + 1'b1;
			end
		end
		if (cmd.frd)
			kw_q <= k_q;
		if (fcap_q)
			fills_q[kw_q] <= fill_rd_q;
		if (cmd.rem_clr)
			rem_q <= '0;
		else if (fcap_q)
			rem_q <= rem_q + clnb_pkg::REM_W'(fill_rd_q);
		else if (cmd.rem_dec)
			rem_q <= rem_q - 1'b1;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.emit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			member_index <= cmd.e_found ? mrd_q : '0;
			found        <= cmd.e_found;
			out_cell_x   <= cmd.e_cell ? locx_q : '0;
			out_cell_y   <= cmd.e_cell ? locy_q : '0;
			status       <= cmd.e_status;
			last         <= cmd.e_last;
		end
	end

	assign clr_q = clr_cnt_q[clnb_pkg::CELL_W-1:clnb_pkg::GRID_W];

	always_comb begin
		st.op         = op_q;
		st.clr_last   = (&clr_q) && (&clr_cnt_q[clnb_pkg::GRID_W-1:0]);
		st.loc_ok     = okx_q && oky_q;
		st.idx_bad    = (32'(idx_q) >= 32'(clnb_pkg::PARTICLE_MAX));
		st.fill_full  = (fill_rd_q >= clnb_pkg::SLOT_W'(clnb_pkg::BOX_CAP));
		st.same_cell  = (cx_q == nx_q) && (cy_q == ny_q);
		st.mv_oob     = ({1'b0, cx_q} >= g) || ({1'b0, cy_q} >= g) ||
		                ({1'b0, nx_q} >= g) || ({1'b0, ny_q} >= g);
		st.q_oob      = ({1'b0, cx_q} >= g) || ({1'b0, cy_q} >= g);
		st.slot_end   = (slot_q == n_q);
		st.slot_zero  = (slot_q == '0);
		st.present    = present_q;
		st.walk_last  = (wx_q == x1) && (wy_q == y1);
		st.rem_zero   = (rem_q == '0);
		st.rem_one    = (rem_q == clnb_pkg::REM_W'(1));
		st.cell_empty = (fills_q[k_q] == '0);
		st.out_free   = !out_valid || out_ready;
	end

endmodule

// ----- sv/clnb_ctrl.sv -----
// Controller: sequencing state machine for clearing, locate, insert, move and query.
module clnb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  clnb_pkg::clnb_stat_t st,
	output clnb_pkg::clnb_cmd_t  cmd
);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DISP  = 5'd2;
	localparam logic [4:0] S_XLO   = 5'd3;
	localparam logic [4:0] S_XHI   = 5'd4;
	localparam logic [4:0] S_XACC  = 5'd5;
	localparam logic [4:0] S_XSAVE = 5'd6;
	localparam logic [4:0] S_YLO   = 5'd7;
	localparam logic [4:0] S_YHI   = 5'd8;
	localparam logic [4:0] S_YACC  = 5'd9;
	localparam logic [4:0] S_YSAVE = 5'd10;
	localparam logic [4:0] S_LEND  = 5'd11;
	localparam logic [4:0] S_INS   = 5'd12;
	localparam logic [4:0] S_EMIT  = 5'd13;
	localparam logic [4:0] S_MV    = 5'd14;
	localparam logic [4:0] S_MVN   = 5'd15;
	localparam logic [4:0] S_SCAN  = 5'd16;
	localparam logic [4:0] S_SCANE = 5'd17;
	localparam logic [4:0] S_MVCHK = 5'd18;
	localparam logic [4:0] S_CMP   = 5'd19;
	localparam logic [4:0] S_CMPE  = 5'd20;
	localparam logic [4:0] S_FIN1  = 5'd21;
	localparam logic [4:0] S_FIN2  = 5'd22;
	localparam logic [4:0] S_Q     = 5'd23;
	localparam logic [4:0] S_QF    = 5'd24;
	localparam logic [4:0] S_QFE   = 5'd25;
	localparam logic [4:0] S_QP2   = 5'd26;
	localparam logic [4:0] S_QCELL = 5'd27;
	localparam logic [4:0] S_QRD   = 5'd28;
	localparam logic [4:0] S_QEMIT = 5'd29;

	logic [4:0] state_q, state_d;
	logic [1:0] rstat_q, rstat_d;
	logic       rcell_q, rcell_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		rstat_d = rstat_q;
		rcell_d = rcell_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.fwr      = 1'b1;
				cmd.fwr_sel  = clnb_pkg::FW_CLR;
				cmd.clr_step = 1'b1;
				if (st.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid)
					state_d = S_DISP;
			end
			S_DISP: begin
				case (st.op)
					clnb_pkg::OP_MOVE:  state_d = S_MV;
					clnb_pkg::OP_QUERY: state_d = S_Q;
					default:            state_d = S_XLO;
				endcase
			end
			S_XLO, S_YLO: begin
				cmd.mul    = 1'b1;
				cmd.axis_y = (state_q == S_YLO);
				state_d    = (state_q == S_YLO) ? S_YHI : S_XHI;
			end
			S_XHI, S_YHI: begin
				cmd.acc_lo = 1'b1;
				cmd.mul    = 1'b1;
				cmd.mul_hi = 1'b1;
				cmd.axis_y = (state_q == S_YHI);
				state_d    = (state_q == S_YHI) ? S_YACC : S_XACC;
			end
			S_XACC, S_YACC: begin
				cmd.acc_hi = 1'b1;
				state_d    = (state_q == S_YACC) ? S_YSAVE : S_XSAVE;
			end
			S_XSAVE, S_YSAVE: begin
				cmd.save   = 1'b1;
				cmd.axis_y = (state_q == S_YSAVE);
				state_d    = (state_q == S_YSAVE) ? S_LEND : S_YLO;
			end
			S_LEND: begin
				state_d = S_EMIT;
				if (!st.loc_ok) begin
					rstat_d = clnb_pkg::ST_OUTSIDE;
					rcell_d = 1'b0;
				end else if (st.op == clnb_pkg::OP_LOCATE) begin
					rstat_d = clnb_pkg::ST_OK;
					rcell_d = 1'b1;
				end else if (st.idx_bad) begin
					rstat_d = clnb_pkg::ST_MISSING;
					rcell_d = 1'b1;
				end else begin
					cmd.frd     = 1'b1;
					cmd.frd_sel = clnb_pkg::FR_LOC;
					state_d     = S_INS;
				end
			end
			S_INS: begin
				rcell_d = 1'b1;
				state_d = S_EMIT;
				if (st.fill_full) begin
					rstat_d = clnb_pkg::ST_FULL;
				end else begin
					rstat_d     = clnb_pkg::ST_OK;
					cmd.mwr_ins = 1'b1;
					cmd.fwr     = 1'b1;
					cmd.fwr_sel = clnb_pkg::FW_LOC;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.e_status = rstat_q;
					cmd.e_cell   = rcell_q;
					cmd.e_last   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_MV: begin
				rcell_d = 1'b0;
				if (st.same_cell) begin
					rstat_d = clnb_pkg::ST_OK;
					state_d = S_EMIT;
				end else if (st.mv_oob) begin
					rstat_d = clnb_pkg::ST_OUTSIDE;
					state_d = S_EMIT;
				end else begin
					cmd.frd     = 1'b1;
					cmd.frd_sel = clnb_pkg::FR_OLD;
					state_d     = S_MVN;
				end
			end
			S_MVN: begin
				cmd.n_load   = 1'b1;
				cmd.slot_clr = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				if (st.slot_end)
					state_d = S_SCANE;
				else
					cmd.scan_rd = 1'b1;
			end
			S_SCANE: begin
				cmd.frd     = 1'b1;
				cmd.frd_sel = clnb_pkg::FR_NEW;
				state_d     = S_MVCHK;
			end
			S_MVCHK: begin
				if (st.idx_bad || !st.present) begin
					rstat_d = clnb_pkg::ST_MISSING;
					state_d = S_EMIT;
				end else if (st.fill_full) begin
					rstat_d = clnb_pkg::ST_FULL;
					state_d = S_EMIT;
				end else begin
					cmd.fnew_load = 1'b1;
					cmd.slot_clr  = 1'b1;
					state_d       = S_CMP;
				end
			end
			S_CMP: begin
				if (st.slot_end)
					state_d = S_CMPE;
				else
					cmd.cmp_rd = 1'b1;
			end
			S_CMPE: state_d = S_FIN1;
			S_FIN1: begin
				cmd.fwr     = 1'b1;
				cmd.fwr_sel = clnb_pkg::FW_OLD;
				state_d     = S_FIN2;
			end
			S_FIN2: begin
				cmd.mwr_new = 1'b1;
				cmd.fwr     = 1'b1;
				cmd.fwr_sel = clnb_pkg::FW_NEW;
				rstat_d     = clnb_pkg::ST_OK;
				state_d     = S_EMIT;
			end
			S_Q: begin
				rcell_d = 1'b0;
				if (st.q_oob) begin
					rstat_d = clnb_pkg::ST_OUTSIDE;
					state_d = S_EMIT;
				end else begin
					cmd.walk_init = 1'b1;
					cmd.rem_clr   = 1'b1;
					state_d       = S_QF;
				end
			end
			S_QF: begin
				cmd.frd     = 1'b1;
				cmd.frd_sel = clnb_pkg::FR_WALK;
				if (st.walk_last)
					state_d = S_QFE;
				else
					cmd.walk_next = 1'b1;
			end
			S_QFE: state_d = S_QP2;
			S_QP2: begin
				if (st.rem_zero) begin
					rstat_d = clnb_pkg::ST_OK;
					state_d = S_EMIT;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = S_QCELL;
				end
			end
			S_QCELL: begin
				if (st.cell_empty) begin
					cmd.walk_next = 1'b1;
				end else begin
					cmd.q_load = 1'b1;
					state_d    = S_QRD;
				end
			end
			S_QRD: begin
				cmd.qrd = 1'b1;
				state_d = S_QEMIT;
			end
			S_QEMIT: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.e_status = clnb_pkg::ST_OK;
					cmd.e_found  = 1'b1;
					cmd.e_last   = st.rem_one;
					cmd.rem_dec  = 1'b1;
					if (st.rem_one) begin
						state_d = S_IDLE;
					end else if (st.slot_zero) begin
						cmd.walk_next = 1'b1;
						state_d       = S_QCELL;
					end else begin
						state_d = S_QRD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			rstat_q <= clnb_pkg::ST_OK;
			rcell_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rstat_q <= rstat_d;
			rcell_q <= rcell_d;
		end
	end

endmodule

// ----- sv/cell_list_neighbor_binning_top.sv -----
// Top level of the two-dimensional cell-list neighbour binning engine.
//
//   Channel  | Direction | Handshake              | Word
//   ---------+-----------+------------------------+-------------------------------------
//   in       | input     | in_valid / in_ready    | operation, index, position, cells
//   out      | output    | out_valid / out_ready  | member, found, cell, status, last
//   cfg      | input     | cfg_we, no wait        | cfg_index selects, cfg_data value
//
// After reset the engine clears the fill count of every cell and takes no input word
// in that time; configuration writes are taken throughout.
// One word is worked on at a time. Locate is dominated by the two partial products per
// axis of the shared 16 x 25 multiplier; insert adds a fill count check and write.
// A move reads the n entries of the old cell twice, once to find the particle and once
// more to compact it, since the member store has a single read port. A query first
// reads the fill counts of the up to nine cells of its block, then gives one result
// word per member, up to 63 in all, stepping through the cells of its block in turn.
// A stalled output holds the result register and the sequencer waits on it.
module cell_list_neighbor_binning_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [clnb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [clnb_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         operation,
	input  logic [clnb_pkg::IDX_W-1:0]         particle_index,
	input  logic signed [clnb_pkg::POS_W-1:0]  pos_x,
	input  logic signed [clnb_pkg::POS_W-1:0]  pos_y,
	input  logic [clnb_pkg::GRID_W-1:0]        cell_x,
	input  logic [clnb_pkg::GRID_W-1:0]        cell_y,
	input  logic [clnb_pkg::GRID_W-1:0]        new_cell_x,
	input  logic [clnb_pkg::GRID_W-1:0]        new_cell_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [clnb_pkg::IDX_W-1:0]         member_index,
	output logic                               found,
	output logic [clnb_pkg::GRID_W-1:0]        out_cell_x,
	output logic [clnb_pkg::GRID_W-1:0]        out_cell_y,
	output logic [1:0]                         status,
	output logic                               last
);

	// The controller and the datapath meet only through these two structures.
	clnb_pkg::clnb_cmd_t  cmd;
	clnb_pkg::clnb_stat_t st;

	clnb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, both cell stores and the result register.
	clnb_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.particle_index (particle_index),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.cell_x         (cell_x),
		.cell_y         (cell_y),
		.new_cell_x     (new_cell_x),
		.new_cell_y     (new_cell_y),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.member_index   (member_index),
		.found          (found),
		.out_cell_x     (out_cell_x),
		.out_cell_y     (out_cell_y),
		.status         (status),
		.last           (last)
	);

	// A member word always carries a good status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == clnb_pkg::ST_OK)
		else $error("member word with a bad status");

	// A word without a member is always the only and final word of its input.
	a_nofound_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last)
		else $error("empty word not marked last");

	// An outside position never reports a cell.
	a_outside_nocell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == clnb_pkg::ST_OUTSIDE |-> out_cell_x == '0 && out_cell_y == '0)
		else $error("outside status with a cell");

	// No input word is taken while the clearing sweep is still going.
	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !in_ready)
		else $error("input taken during clearing");

endmodule
